@@ rtl/life_grid_generation_step_assert.svh @@
// Assertion macros for the checker file of the life grid block.
// Needs no package; each macro takes its clock and active-low reset by argument.
`ifndef LIFE_GRID_GENERATION_STEP_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("life grid assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("life grid assertion failed");

`endif

@@ rtl/lgs_pkg.sv @@
// Shared constants, types and codes of the life grid generation block.
// No dependencies; every module imports this package.
package lgs_pkg;

  // Grid size.
  localparam int ROWS = 32;
  localparam int COLS = 32;

  // Index widths that address one row or one column.
  localparam int RIDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CIDX_W = (COLS > 1) ? $clog2(COLS) : 1;

  // Neighbor counts of the B3/S23 rule.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Configuration register map.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_RUNNING = 3'd0;

  // Command codes carried with each input item.
  typedef enum logic [1:0] {
    MODE_STEP  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } lgs_mode_t;

  // Controls broadcast to every row cell.
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic              wr_en;
    logic [CIDX_W-1:0] wr_col;
    logic              wr_val;
  } lgs_cell_ctrl_t;

endpackage

@@ rtl/lgs_row_cell.sv @@
// One row of the grid: a register that takes its neighbor's row on a shift,
// is cleared as a whole, or has one bit written. Depends on lgs_pkg.
module lgs_row_cell
  import lgs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  lgs_cell_ctrl_t      ctrl,
  input  logic                sel,
  input  logic [COLS-1:0]     shift_in,
  output logic [COLS-1:0]     row_q
);

  logic [COLS-1:0] row_r;
  logic [COLS-1:0] row_nxt;

  // Clear wins, then a shift during a generation, then a single-cell write.
  always_comb begin
    row_nxt = row_r;
    if (ctrl.clear) begin
      row_nxt = '0;
    end else if (ctrl.shift) begin
      row_nxt = shift_in;
    end else if (ctrl.wr_en && sel) begin
      row_nxt[ctrl.wr_col] = ctrl.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign row_q = row_r;

endmodule

@@ rtl/lgs_rule.sv @@
// Next-generation logic for one row from the rows above, at and below it.
// Columns past either edge count as dead. Depends on lgs_pkg.
module lgs_rule
  import lgs_pkg::*;
(
  input  logic [COLS-1:0] above,
  input  logic [COLS-1:0] mid,
  input  logic [COLS-1:0] below,
  output logic [COLS-1:0] nxt
);

  logic [COLS+1:0] above_x;
  logic [COLS+1:0] mid_x;
  logic [COLS+1:0] below_x;

  // Pad a dead column on each side so every cell sees the same window.
  assign above_x = {1'b0, above, 1'b0};
  assign mid_x   = {1'b0, mid, 1'b0};
  assign below_x = {1'b0, below, 1'b0};

  // Each column counts its eight neighbors independently.
  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int c = 0; c < COLS; c++) begin
      n = 4'(above_x[c]) + 4'(above_x[c+1]) + 4'(above_x[c+2])
        + 4'(mid_x[c])                      + 4'(mid_x[c+2])
        + 4'(below_x[c]) + 4'(below_x[c+1]) + 4'(below_x[c+2]);
      nxt[c] = (n == BIRTH_COUNT) || (mid[c] && (n == SURVIVE_COUNT));
    end
  end

endmodule

@@ rtl/life_grid_generation_step.sv @@
// Channel   Dir  Contents
// in_*      in   tuser: mode; tdata: row, col, value
// out_*     out  tdata: cell_value
// cfg_*     in   APB register port, register running at address 0
//
// During a generation the rows rotate through the cell chain one per cycle
// past a single row of rule logic.
// Write, clear, read and a frozen step give their result one cycle after accept.
// Reset is synchronous, active low; it clears the grid and sets running to 1.
// A waiting result holds off the next item until out_tready takes it.
// Depends on lgs_pkg, lgs_row_cell and lgs_rule.
module life_grid_generation_step
  import lgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [4:0] row, [9:5] col, [10] value
  input  logic [1:0]            in_tuser,   // [1:0] mode
  // Result items.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [0] cell_value
  // Configuration.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic [4:0]        in_row;
  logic [4:0]        in_col;
  logic              in_value;
  lgs_mode_t         in_mode;
  logic              in_acc;
  logic              on_grid;
  logic [RIDX_W-1:0] row_idx;
  logic [CIDX_W-1:0] col_idx;

  logic              running_r;
  logic              busy_r,     busy_nxt;
  logic [RIDX_W-1:0] cnt_r,      cnt_nxt;
  logic [COLS-1:0]   prev_r,     prev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_r,  out_cell_nxt;
  logic              last_row;

  lgs_cell_ctrl_t    ctrl;
  logic [COLS-1:0]   rows [ROWS];
  logic [COLS-1:0]   below_row;
  logic [COLS-1:0]   new_row;

  // Field unpacking and address checks.
  assign in_row   = in_tdata[4:0];
  assign in_col   = in_tdata[9:5];
  assign in_value = in_tdata[10];
  assign in_mode  = lgs_mode_t'(in_tuser);
  assign on_grid  = (int'(in_row) < ROWS) && (int'(in_col) < COLS);
  assign row_idx  = RIDX_W'(in_row);
  assign col_idx  = CIDX_W'(in_col);

  // One item at a time; the output register must be free or draining.
  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == CFG_ADDR_RUNNING) ? {31'b0, running_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == CFG_ADDR_RUNNING)) begin
      running_r <= cfg_pwdata[0];
    end
  end

  // Controls broadcast along the chain.
  always_comb begin
    ctrl.shift  = busy_r;
    ctrl.clear  = in_acc && (in_mode == MODE_CLEAR);
    ctrl.wr_en  = in_acc && (in_mode == MODE_WRITE) && on_grid;
    ctrl.wr_col = col_idx;
    ctrl.wr_val = in_value;
  end

  // Row 0 of the chain is the row being updated; row 1 is the old row below.
  assign last_row  = (cnt_r == RIDX_W'(ROWS - 1));
  assign below_row = last_row ? '0 : rows[1];

  lgs_rule u_rule (
    .above (prev_r),
    .mid   (rows[0]),
    .below (below_row),
    .nxt   (new_row)
  );

  // Chain of row cells; the updated row re-enters at the tail.
  for (genvar g = 0; g < ROWS; g++) begin : g_cell
    logic [COLS-1:0] shift_in;
    if (g == ROWS - 1) begin : g_tail
      assign shift_in = new_row;
    end else begin : g_link
      assign shift_in = rows[g+1];
    end
    lgs_row_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .sel      (row_idx == RIDX_W'(g)),
      .shift_in (shift_in),
      .row_q    (rows[g])
    );
  end

  // Sequencing of a generation and the result register.
  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_cell_nxt  = out_cell_r;
    if (busy_r) begin
      prev_nxt = rows[0];
      cnt_nxt  = cnt_r + 1'b1;
      if (last_row) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_cell_nxt  = 1'b0;
      end
    end else if (in_acc) begin
      if ((in_mode == MODE_STEP) && running_r) begin
        busy_nxt = 1'b1;
        cnt_nxt  = '0;
        prev_nxt = '0;
      end else begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = (in_mode == MODE_READ) && on_grid && rows[row_idx][col_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    out_cell_r <= out_cell_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_cell_r};

endmodule

@@ rtl/lgs_checker.sv @@
// Port-level checks of the life grid block, bound to its top level.
// Depends on lgs_pkg and life_grid_generation_step_assert.svh.
`include "life_grid_generation_step_assert.svh"

module lgs_checker
  import lgs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [1:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [7:0]            out_tdata
);

  // A stalled result keeps its value.
  `LGS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // An item is only taken when the result slot is free or draining.
  `LGS_ASSERT_NOW(a_slot_free, clk, rst_n, in_tready, !out_tvalid || out_tready)

  // Anything but a step command answers in the next cycle.
  `LGS_ASSERT_NEXT(a_fast_result, clk, rst_n, in_tvalid && in_tready && (in_tuser != MODE_STEP), out_tvalid)

  // Only the cell bit of a result can be set.
  `LGS_ASSERT_NOW(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[7:1] == 7'b0)

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (.*);

@@ dv/testbench.sv @@
// Self-checking testbench of the life grid block: a B3/S23 engine on a 32 by 32 grid.
// It drives commands and APB register writes, predicts each result and checks them in order.
// Depends on lgs_pkg and life_grid_generation_step.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lgs_pkg::*;

  localparam int LONG_HOLD = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [4:0] row, [9:5] col, [10] value
  logic [1:0]  in_tuser = '0;   // [1:0] mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [0] cell_value
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // One expected result, with the command that caused it for messages.
  typedef struct {
    lgs_mode_t  mode;
    logic [4:0] row;
    logic [4:0] col;
    logic       value_bit;
  } cell_answer_t;

  // Predicted grid, register copy and the queue of expected results.
  logic [COLS-1:0] life_grid [ROWS];
  logic            running_now;
  cell_answer_t    cell_answers [$];

  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned mode_count [4] = '{0, 0, 0, 0};
  int unsigned live_reads = 0;
  int unsigned frozen_steps = 0;
  bit          calm = 1'b0;
  bit          hold_request = 1'b0;

  always #5 clk = ~clk;

  life_grid_generation_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Applies one command to the predicted grid and returns the result it should give.
  function automatic cell_answer_t apply_command(lgs_mode_t mode, logic [4:0] row,
                                                 logic [4:0] col, logic value);
    cell_answer_t    ans;
    logic [COLS-1:0] next_rows [ROWS];
    int              live;
    bit              on_grid;
    ans.mode = mode;
    ans.row = row;
    ans.col = col;
    ans.value_bit = 1'b0;
    on_grid = (int'(row) < ROWS) && (int'(col) < COLS);
    mode_count[int'(mode)]++;
    case (mode)
      MODE_STEP: begin
        if (running_now) begin
          // Count the eight neighbors; anything past an edge is dead, nothing wraps.
          for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
              live = 0;
              for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                  if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < ROWS &&
                      c + dc >= 0 && c + dc < COLS)
                    live += life_grid[r + dr][c + dc];
              next_rows[r][c] = (live == 3) || (life_grid[r][c] && live == 2);
            end
          end
          life_grid = next_rows;
        end else begin
          frozen_steps++;
        end
      end
      MODE_WRITE: begin
        if (on_grid) life_grid[row][col] = value;
      end
      MODE_CLEAR: begin
        foreach (life_grid[r]) life_grid[r] = '0;
      end
      MODE_READ: begin
        if (on_grid) ans.value_bit = life_grid[row][col];
        if (ans.value_bit) live_reads++;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Result side first, then the accepted item, so a result and the next
  // item taken at the same edge stay in order.
  always @(posedge clk) begin
    cell_answer_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (cell_answers.size() == 0) begin
          if (error_count < 20)
            $display("%0t: unexpected result, expected none, got cell %0b", $time, out_tdata[0]);
          error_count++;
        end else begin
          want = cell_answers.pop_front();
          if (out_tdata[0] !== want.value_bit) begin
            if (error_count < 20)
              $display("%0t: %s row %0d col %0d: expected cell %0b, got %0b", $time,
                       want.mode.name(), want.row, want.col, want.value_bit, out_tdata[0]);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        cell_answers.insert(cell_answers.size(),
                            apply_command(lgs_mode_t'(in_tuser), in_tdata[4:0],
                                          in_tdata[9:5], in_tdata[10]));
    end
  end

  // Result receiver: short random stalls, a long hold-off on request, none when calm.
  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one item, after an optional idle burst, and returns at its accept edge.
  task automatic send_command(lgs_mode_t mode, logic [4:0] row, logic [4:0] col,
                              logic value);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {5'd0, value, col, row};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stops offering items until every result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_seen < items_sent);
  endtask

  // Writes the running register while idle, then reads it back.
  task automatic write_running(logic value);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_RUNNING;
    cfg_pwdata <= {31'd0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    running_now = value;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[0] !== value) begin
      $display("%0t: running read back: expected %0b, got %0b", $time, value, cfg_prdata[0]);
      error_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Random commands of any mode at any address.
  task automatic send_noise(int unsigned count);
    repeat (count)
      send_command(lgs_mode_t'($urandom_range(0, 3)), 5'($urandom), 5'($urandom),
                   1'($urandom));
  endtask

  // Corner cells: empty grid after reset, set and clear a cell, lone cells dying.
  task automatic check_corners();
    send_command(MODE_READ, 5'd0, 5'd0, 1'b1);
    send_command(MODE_WRITE, 5'd0, 5'd0, 1'b1);
    send_command(MODE_WRITE, 5'd0, 5'd31, 1'b1);
    send_command(MODE_WRITE, 5'd31, 5'd0, 1'b1);
    send_command(MODE_WRITE, 5'd31, 5'd31, 1'b1);
    send_command(MODE_READ, 5'd31, 5'd31, 1'b0);
    send_command(MODE_WRITE, 5'd0, 5'd0, 1'b0);
    send_command(MODE_READ, 5'd0, 5'd0, 1'b0);
    send_command(MODE_STEP, 5'd31, 5'd31, 1'b1);
    send_command(MODE_READ, 5'd31, 5'd0, 1'b1);
  endtask

  // A blinker against the right edge must not give birth on the left edge.
  task automatic check_edge_no_wrap();
    send_command(MODE_CLEAR, 5'd31, 5'd31, 1'b1);
    send_command(MODE_WRITE, 5'd10, 5'd31, 1'b1);
    send_command(MODE_WRITE, 5'd11, 5'd31, 1'b1);
    send_command(MODE_WRITE, 5'd12, 5'd31, 1'b1);
    send_command(MODE_STEP, 5'd0, 5'd0, 1'b0);
    send_command(MODE_READ, 5'd11, 5'd0, 1'b0);
    send_command(MODE_READ, 5'd11, 5'd30, 1'b0);
  endtask

  // A step with running cleared leaves the grid as it is; with running set it evolves.
  task automatic check_frozen_step();
    write_running(1'b0);
    send_command(MODE_STEP, 5'd11, 5'd31, 1'b1);
    send_command(MODE_READ, 5'd11, 5'd30, 1'b0);
    write_running(1'b1);
    send_command(MODE_STEP, 5'd11, 5'd31, 1'b1);
    send_command(MODE_READ, 5'd11, 5'd30, 1'b0);
  endtask

  // Clear wipes every cell, whatever its address fields say.
  task automatic check_clear();
    send_command(MODE_CLEAR, 5'd0, 5'd0, 1'b0);
    send_command(MODE_READ, 5'd11, 5'd31, 1'b1);
  endtask

  // The receiver holds off while a glider is built, so the block stalls its input.
  task automatic check_backpressure();
    wait_drained();
    hold_request = 1'b1;
    send_command(MODE_WRITE, 5'd1, 5'd2, 1'b1);
    send_command(MODE_WRITE, 5'd2, 5'd3, 1'b1);
    send_command(MODE_WRITE, 5'd3, 5'd1, 1'b1);
    send_command(MODE_WRITE, 5'd3, 5'd2, 1'b1);
    send_command(MODE_WRITE, 5'd3, 5'd3, 1'b1);
    send_command(MODE_STEP, 5'($urandom), 5'($urandom), 1'($urandom));
    for (int r = 2; r <= 4; r++)
      for (int c = 1; c <= 3; c++)
        send_command(MODE_READ, 5'(r), 5'(c), 1'($urandom));
    wait_drained();
  endtask

  // Small colonies seeded in a window that may straddle the edges, evolved and probed.
  task automatic grow_colonies(int unsigned item_goal);
    int unsigned goal;
    logic [4:0]  r0;
    logic [4:0]  c0;
    int          span;
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) == 0)
        send_command(MODE_CLEAR, 5'($urandom), 5'($urandom), 1'($urandom));
      r0 = ($urandom_range(0, 2) == 0) ? 5'd30 : 5'($urandom);
      c0 = ($urandom_range(0, 2) == 0) ? 5'd30 : 5'($urandom);
      span = $urandom_range(3, 7);
      repeat ($urandom_range(4, 16))
        send_command(MODE_WRITE, r0 + 5'($urandom_range(0, span - 1)),
                     c0 + 5'($urandom_range(0, span - 1)), $urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 3))
        send_command(MODE_STEP, 5'($urandom), 5'($urandom), 1'($urandom));
      repeat ($urandom_range(4, 12))
        send_command(MODE_READ, r0 + 5'($urandom_range(0, span + 1)) - 5'd1,
                     c0 + 5'($urandom_range(0, span + 1)) - 5'd1, 1'($urandom));
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 3));
      if (!calm && $urandom_range(0, 7) == 0) wait_drained();
    end
  endtask

  // Random writes, steps and reads with the grid frozen.
  task automatic run_frozen_mix(int unsigned count);
    write_running(1'b0);
    repeat (count) begin
      case ($urandom_range(0, 2))
        0: send_command(MODE_STEP, 5'($urandom), 5'($urandom), 1'($urandom));
        1: send_command(MODE_WRITE, 5'($urandom), 5'($urandom), 1'($urandom));
        default: send_command(MODE_READ, 5'($urandom), 5'($urandom), 1'($urandom));
      endcase
    end
    write_running(1'b1);
  endtask

  initial begin : test_sequence
    foreach (life_grid[r]) life_grid[r] = '0;
    running_now = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_corners();
    check_edge_no_wrap();
    check_frozen_step();
    check_clear();
    check_backpressure();
    grow_colonies(520);
    run_frozen_mix(70);
    send_noise(160);
    // Last stretch runs with no idling on either side.
    calm = 1'b1;
    grow_colonies(140);

    wait_drained();
    repeat (40) @(posedge clk);
    if (cell_answers.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, cell_answers.size());
      error_count++;
    end
    $display("Ran %0d items: %0d steps (%0d frozen), %0d writes, %0d clears,",
             items_sent, mode_count[MODE_STEP], frozen_steps, mode_count[MODE_WRITE],
             mode_count[MODE_CLEAR]);
    $display("%0d reads (%0d live); running toggled both ways, edge colonies and stalls.",
             mode_count[MODE_READ], live_reads);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d of %0d results checked.", results_seen, items_sent);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
